### rtl/bship_pkg.sv
// Shared widths, register codes and reset values for the burning ship evaluator.
package bship_pkg;

	localparam int QW      = 32;
	localparam int FRAC_W  = 28;
	localparam int STEP_W  = 28;
	localparam int PIX_W   = 10;
	localparam int CNT_W   = 16;
	localparam int MAG_W   = 31;
	localparam int PROD_W  = 2 * MAG_W;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIXEL_STEP = 2'd0,
		REG_ORIGIN_RE  = 2'd1,
		REG_ORIGIN_IM  = 2'd2,
		REG_ITER_LIMIT = 2'd3
	} cfg_reg_t;

	localparam logic [STEP_W-1:0]    STEP_RST   = 28'd1789570;
	localparam logic signed [QW-1:0] ORE_RST    = -32'sd536870912;
	localparam logic signed [QW-1:0] OIM_RST    = -32'sd563714458;
	localparam logic [CNT_W-1:0]     LIMIT_RST  = 16'd30;

endpackage

### rtl/bship_mul.sv
// Shared registered unsigned multiplier used for coordinate mapping, squaring and the z_re*z_im product.
module bship_mul (
	input  logic                             clk,
	input  logic [bship_pkg::MAG_W-1:0]      a,
	input  logic [bship_pkg::MAG_W-1:0]      b,
	output logic [bship_pkg::PROD_W-1:0]     prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

### rtl/burning_ship_escape_time.sv
// Burning ship escape-time evaluator, top level.
//
// Input channel: pixel_x/pixel_y with in_valid/in_stall; a word is taken when
// in_valid is high and in_stall low. Output channel: out_x, out_y,
// iteration_count, escaped with out_valid/out_stall, same rule.
// Configuration: cfg_wr_en writes cfg_data into the register cfg_index names
// (pixel step, origin re, origin im, iteration limit); write only while idle.
//
// One pixel at a time. A single 31x31 multiplier is reused for every product:
// states S_CX, S_CY and S_CI map the pixel to c, then each map iteration steps
// through z_re^2, z_im^2 with escape check, z_re*z_im and update. The next word
// can be accepted in the same cycle as the result appears. in_stall stays high
// while a pixel is in work. A finished result sits in the output register; if
// the receiver stalls, the block holds it and may take a new pixel, but waits
// before delivering the next result until that register is free.
// Reset clears the sequencer and output valid and loads the default
// configuration.
module burning_ship_escape_time (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [bship_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bship_pkg::QW-1:0]            cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bship_pkg::PIX_W-1:0]         pixel_x,
	input  logic [bship_pkg::PIX_W-1:0]         pixel_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bship_pkg::PIX_W-1:0]         out_x,
	output logic [bship_pkg::PIX_W-1:0]         out_y,
	output logic [bship_pkg::CNT_W-1:0]         iteration_count,
	output logic                                escaped
);

	typedef enum logic [3:0] {
		S_IDLE, S_CX, S_CY, S_CI, S_RE2, S_IM2, S_XR, S_UPD, S_DONE
	} state_t;

	state_t state_q;

	logic [bship_pkg::STEP_W-1:0]        step_q;
	logic signed [bship_pkg::QW-1:0]     origin_re_q;
	logic signed [bship_pkg::QW-1:0]     origin_im_q;
	logic [bship_pkg::CNT_W-1:0]         limit_q;

	logic [bship_pkg::PIX_W-1:0]         px_q, py_q;
	logic signed [bship_pkg::QW-1:0]     c_re_q, c_im_q;
	logic [bship_pkg::MAG_W-1:0]         zr_q, zi_q;
	logic [bship_pkg::CNT_W-1:0]         cnt_q;
	logic [bship_pkg::PROD_W-1:0]        re2_q;
	logic signed [bship_pkg::PROD_W:0]   diff_q;
	logic                                esc_q;

	logic                                out_valid_q;
	logic [bship_pkg::PIX_W-1:0]         out_x_q, out_y_q;
	logic [bship_pkg::CNT_W-1:0]         out_cnt_q;
	logic                                out_esc_q;

	logic [bship_pkg::MAG_W-1:0]         mul_a, mul_b;
	logic [bship_pkg::PROD_W-1:0]        prod_q;

	logic signed [39:0]                  c_sum;
	logic signed [bship_pkg::QW-1:0]     c_sat;
	logic [bship_pkg::PROD_W:0]          mag_sum;
	logic signed [bship_pkg::PROD_W:0]   diff_d;
	logic signed [36:0]                  re_sum, im_sum, re_abs, im_abs;
	logic [bship_pkg::MAG_W-1:0]         zr_d, zi_d;
	logic                                accept;

	bship_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign in_stall        = (state_q != S_IDLE);
	assign accept          = in_valid && !in_stall;
	assign out_valid       = out_valid_q;
	assign out_x           = out_x_q;
	assign out_y           = out_y_q;
	assign iteration_count = out_cnt_q;
	assign escaped         = out_esc_q;

	always_comb begin
		case (state_q)
			S_CX: begin
				mul_a = {3'b0, step_q};
				mul_b = {21'b0, px_q};
			end
			S_CY: begin
				mul_a = {3'b0, step_q};
				mul_b = {21'b0, py_q};
			end
			S_CI, S_RE2: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			S_IM2: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			S_XR: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// c = origin + pixel * step, saturated to Q4.28
	always_comb begin
		if (state_q == S_CY)
			c_sum = $signed({{8{origin_re_q[31]}}, origin_re_q}) + $signed({2'b0, prod_q[37:0]});
		else
			c_sum = $signed({{8{origin_im_q[31]}}, origin_im_q}) + $signed({2'b0, prod_q[37:0]});
		if (c_sum[39:31] == '0 || c_sum[39:31] == '1)
			c_sat = c_sum[31:0];
		else if (c_sum[39])
			c_sat = {1'b1, 31'b0};
		else
			c_sat = {1'b0, {31{1'b1}}};
	end

	// escape check and map update
	always_comb begin
		mag_sum = {1'b0, re2_q} + {1'b0, prod_q};
		diff_d  = $signed({1'b0, re2_q}) - $signed({1'b0, prod_q});
		re_sum  = $signed({{2{diff_q[62]}}, diff_q[62:28]}) +
			$signed({{5{c_re_q[31]}}, c_re_q});
		im_sum  = $signed({2'b0, prod_q[61:27]}) + $signed({{5{c_im_q[31]}}, c_im_q});
		re_abs  = re_sum[36] ? -re_sum : re_sum;
		im_abs  = im_sum[36] ? -im_sum : im_sum;
		zr_d    = (re_abs[36:31] != '0) ? {31{1'b1}} : re_abs[30:0];
		zi_d    = (im_abs[36:31] != '0) ? {31{1'b1}} : im_abs[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= bship_pkg::STEP_RST;
			origin_re_q <= bship_pkg::ORE_RST;
			origin_im_q <= bship_pkg::OIM_RST;
			limit_q     <= bship_pkg::LIMIT_RST;
			px_q        <= '0;
			py_q        <= '0;
			c_re_q      <= '0;
			c_im_q      <= '0;
			zr_q        <= '0;
			zi_q        <= '0;
			cnt_q       <= '0;
			re2_q       <= '0;
			diff_q      <= '0;
			esc_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_cnt_q   <= '0;
			out_esc_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (bship_pkg::cfg_reg_t'(cfg_index))
					bship_pkg::REG_PIXEL_STEP: step_q      <= cfg_data[bship_pkg::STEP_W-1:0];
					bship_pkg::REG_ORIGIN_RE:  origin_re_q <= cfg_data;
					bship_pkg::REG_ORIGIN_IM:  origin_im_q <= cfg_data;
					bship_pkg::REG_ITER_LIMIT: limit_q     <= cfg_data[bship_pkg::CNT_W-1:0];
					default: ;
				endcase
			end

			if (state_q == S_DONE && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						px_q    <= pixel_x;
						py_q    <= pixel_y;
						zr_q    <= '0;
						zi_q    <= '0;
						cnt_q   <= '0;
						state_q <= S_CX;
					end
				end
				S_CX: state_q <= S_CY;
				S_CY: begin
					c_re_q  <= c_sat;
					state_q <= S_CI;
				end
				S_CI: begin
					c_im_q  <= c_sat;
					state_q <= S_IM2;
				end
				S_RE2: state_q <= S_IM2;
				S_IM2: begin
					re2_q   <= prod_q;
					state_q <= S_XR;
				end
				S_XR: begin
					diff_q <= diff_d;
					if (cnt_q == limit_q) begin
						esc_q   <= 1'b0;
						state_q <= S_DONE;
					end else if (mag_sum[62:58] != '0) begin
						esc_q   <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					zr_q    <= zr_d;
					zi_q    <= zi_d;
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_RE2;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_x_q     <= px_q;
						out_y_q     <= py_q;
						out_cnt_q   <= cnt_q;
						out_esc_q   <= esc_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/bship_checker.sv
// Port-level checks for the burning ship evaluator and their bind.
module bship_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [bship_pkg::PIX_W-1:0]      out_x,
	input logic [bship_pkg::PIX_W-1:0]      out_y,
	input logic [bship_pkg::CNT_W-1:0]      iteration_count,
	input logic                             escaped
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_x) && $stable(out_y) &&
			$stable(iteration_count) && $stable(escaped))
		else $error("result word changed under stall");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while pixel in work");

	a_escape_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && escaped |-> iteration_count != '0)
		else $error("escape reported with zero iterations");

endmodule

bind burning_ship_escape_time bship_checker u_bship_checker (.*);

### tb/sv/burning_ship_escape_time_tb.sv
// Testbench for the burning ship evaluator: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps

module burning_ship_escape_time_tb;

	typedef struct packed {
		logic [bship_pkg::PIX_W-1:0] x;
		logic [bship_pkg::PIX_W-1:0] y;
		logic [bship_pkg::CNT_W-1:0] count;
		logic                        escaped;
	} ship_result_t;

	localparam longint Q_POS_MAX = 64'sd2147483647;
	localparam longint Q_NEG_MIN = -64'sd2147483648;
	localparam longint ESCAPE_SQ = 64'sd288230376151711744;
	localparam int     RANDOM_PHASES = 12;
	localparam int     WORDS_PER_PHASE = 125;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [bship_pkg::CFG_IDX_W-1:0] cfg_index = bship_pkg::REG_PIXEL_STEP;
	logic [bship_pkg::QW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [bship_pkg::PIX_W-1:0] pixel_x = '0;
	logic [bship_pkg::PIX_W-1:0] pixel_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [bship_pkg::PIX_W-1:0] out_x;
	logic [bship_pkg::PIX_W-1:0] out_y;
	logic [bship_pkg::CNT_W-1:0] iteration_count;
	logic escaped;

	logic [bship_pkg::STEP_W-1:0] shadow_step = bship_pkg::STEP_RST;
	logic signed [bship_pkg::QW-1:0] shadow_ore = bship_pkg::ORE_RST;
	logic signed [bship_pkg::QW-1:0] shadow_oim = bship_pkg::OIM_RST;
	logic [bship_pkg::CNT_W-1:0] shadow_limit = bship_pkg::LIMIT_RST;

	bit in_idle_en = 1'b1;
	bit out_idle_en = 1'b1;
	ship_result_t predicted_pixels[$];
	int mismatch_count = 0;

	burning_ship_escape_time dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_x(out_x),
		.out_y(out_y),
		.iteration_count(iteration_count),
		.escaped(escaped)
	);

	always #2 clk = ~clk;

	function automatic longint clamp_q(longint v);
		if (v > Q_POS_MAX) return Q_POS_MAX;
		if (v < Q_NEG_MIN) return Q_NEG_MIN;
		return v;
	endfunction

	function automatic longint fold_q(longint v);
		return clamp_q(v < 0 ? -v : v);
	endfunction

	function automatic ship_result_t escape_time(logic [bship_pkg::PIX_W-1:0] px,
			logic [bship_pkg::PIX_W-1:0] py);
		longint c_re, c_im, z_re, z_im, re2, im2, next_re;
		int unsigned n;
		bit gone;
		ship_result_t r;
		c_re = clamp_q(longint'(shadow_ore) + longint'(px) * longint'(shadow_step));
		c_im = clamp_q(longint'(shadow_oim) + longint'(py) * longint'(shadow_step));
		z_re = 0;
		z_im = 0;
		n = 0;
		gone = 1'b0;
		while (n < shadow_limit && !gone) begin
			re2 = z_re * z_re;
			im2 = z_im * z_im;
			if (re2 + im2 >= ESCAPE_SQ) begin
				gone = 1'b1;
			end else begin
				next_re = fold_q(((re2 - im2) >>> bship_pkg::FRAC_W) + c_re);
				z_im = fold_q(((z_re * z_im) >>> (bship_pkg::FRAC_W - 1)) + c_im);
				z_re = next_re;
				n++;
			end
		end
		r.x = px;
		r.y = py;
		r.count = n[bship_pkg::CNT_W-1:0];
		r.escaped = (n < shadow_limit);
		return r;
	endfunction

	task automatic send_pixel(logic [bship_pkg::PIX_W-1:0] x,
			logic [bship_pkg::PIX_W-1:0] y);
		int gap;
		gap = (in_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted_pixels.push_back(escape_time(x, y));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (predicted_pixels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [bship_pkg::CFG_IDX_W-1:0] idx,
			logic [bship_pkg::QW-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic set_config(logic [bship_pkg::QW-1:0] step_word,
			logic [bship_pkg::QW-1:0] ore_word,
			logic [bship_pkg::QW-1:0] oim_word, logic [bship_pkg::QW-1:0] limit_word);
		wait_idle();
		write_reg(bship_pkg::REG_PIXEL_STEP, step_word);
		write_reg(bship_pkg::REG_ORIGIN_RE, ore_word);
		write_reg(bship_pkg::REG_ORIGIN_IM, oim_word);
		write_reg(bship_pkg::REG_ITER_LIMIT, limit_word);
		cfg_wr_en <= 1'b0;
		shadow_step = step_word[bship_pkg::STEP_W-1:0];
		shadow_ore = ore_word;
		shadow_oim = oim_word;
		shadow_limit = limit_word[bship_pkg::CNT_W-1:0];
	endtask

	task automatic test_default_config();
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd0, 10'd1023);
		send_pixel(10'd1023, 10'd0);
		send_pixel(10'h2AA, 10'h155);
		send_pixel(10'h155, 10'h2AA);
		send_pixel(10'd300, 10'd310);
		send_pixel(10'd512, 10'd512);
	endtask

	task automatic test_iteration_limits();
		set_config({4'd0, bship_pkg::STEP_RST}, bship_pkg::ORE_RST, bship_pkg::OIM_RST,
			32'd0);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd700, 10'd200);
		// limit hit on the same step that escapes
		set_config({4'd0, bship_pkg::STEP_RST}, bship_pkg::ORE_RST, bship_pkg::OIM_RST,
			32'd1);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd300, 10'd310);
		set_config({4'd0, bship_pkg::STEP_RST}, bship_pkg::ORE_RST, bship_pkg::OIM_RST,
			32'd65535);
		send_pixel(10'd0, 10'd0);
		// c = 0 never escapes: full limit
		set_config(32'd0, 32'd0, 32'd0, 32'd65535);
		send_pixel(10'd5, 10'd9);
	endtask

	task automatic test_zero_step();
		set_config(32'd0, 32'd0 - 32'd469762048, 32'd0 - 32'd8053063, 32'd40);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd17, 10'd900);
	endtask

	task automatic test_saturation();
		set_config(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd16);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd1, 10'd0);
		send_pixel(10'd0, 10'd1);
		set_config(32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd16);
		send_pixel(10'd1023, 10'd0);
		send_pixel(10'd0, 10'd1023);
	endtask

	task automatic test_random_views();
		logic [bship_pkg::QW-1:0] step_word, ore_word, oim_word, limit_word;
		int mode;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			mode = $urandom_range(0, 9);
			if (mode < 6) begin
				step_word = $urandom_range(32'd1 << 18, 32'd1 << 21);
				ore_word = 32'd0 - $urandom_range(0, 32'd805306368);
				oim_word = 32'd0 - $urandom_range(0, 32'd671088640);
			end else if (mode < 8) begin
				// zoom near the hull
				step_word = $urandom_range(1, 32'd1 << 14);
				ore_word = 32'd0 - 32'd469762048 - $urandom_range(0, 32'd1 << 22);
				oim_word = 32'd0 - $urandom_range(0, 32'd1 << 25);
			end else begin
				step_word = $urandom;
				ore_word = $urandom;
				oim_word = $urandom;
			end
			limit_word = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 128)
				: $urandom_range(1, 48);
			set_config(step_word, ore_word, oim_word, limit_word);
			if (p >= RANDOM_PHASES - 2) begin
				in_idle_en = 1'b0;
				out_idle_en = 1'b0;
			end else begin
				in_idle_en = ($urandom_range(0, 3) != 0);
				out_idle_en = ($urandom_range(0, 3) != 0);
			end
			repeat (WORDS_PER_PHASE)
				send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
		end
	endtask

	always begin
		@(posedge clk);
		if (out_idle_en && $urandom_range(0, 4) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 9)) @(posedge clk);
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		ship_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_pixels.size() == 0) begin
				$error("result word with none pending: x %0d y %0d count %0d", out_x, out_y,
					iteration_count);
				mismatch_count++;
			end else begin
				want = predicted_pixels.pop_front();
				if (out_x !== want.x) begin
					$error("out_x expected %0d actual %0d", want.x, out_x);
					mismatch_count++;
				end
				if (out_y !== want.y) begin
					$error("out_y expected %0d actual %0d", want.y, out_y);
					mismatch_count++;
				end
				if (iteration_count !== want.count) begin
					$error("iteration_count expected %0d actual %0d", want.count,
						iteration_count);
					mismatch_count++;
				end
				if (escaped !== want.escaped) begin
					$error("escaped expected %0d actual %0d", want.escaped, escaped);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_config();
		test_iteration_limits();
		test_zero_step();
		test_saturation();
		test_random_views();
		wait_idle();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
